// ===== hdl/ecd_pkg.sv =====
// Shared types, codes and constants of the event pixel change detector.
// Depends on nothing; the top level, controller and datapath import it.
package ecd_pkg;

	localparam int DEF_FRAME_WIDTH  = 128;
	localparam int DEF_FRAME_HEIGHT = 128;
	localparam int NUM_SLOTS        = 5;
	localparam int LEVEL_W          = 16;
	localparam int MOVE_W           = 19;   // holds NUM_SLOTS * 65535
	localparam int CFG_INDEX_W      = 4;
	localparam int CFG_DATA_W       = 8;

	localparam logic CMD_SAMPLE    = 1'b0;
	localparam logic CMD_THRESHOLD = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_INTERPOLATE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_FULL_UPDATE = CFG_INDEX_W'(1);

	typedef struct packed {
		logic               command;
		logic [6:0]         col;
		logic [6:0]         row;
		logic [LEVEL_W-1:0] value;
		logic               frame_end;
	} pixel_req_t;

	typedef struct packed {
		logic [6:0] event_col;
		logic [6:0] event_row;
		logic       polarity;
		logic [2:0] slot;
		logic       last_of_run;
	} event_req_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  wdata;
	} cfg_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_COUNT,
		ST_UPDATE,
		ST_EMIT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // request accepted this cycle
		logic load_diff;   // register reference, threshold and magnitude
		logic count_init;  // first threshold step
		logic count_step;  // one more threshold step
		logic write_ref;   // store the new reference level
		logic clear_emit;  // restart the event index
		logic emit;        // load the next event into the output register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic live;        // accepted sample must be compared
		logic fire;        // magnitude above threshold
		logic interp;      // interpolating mode
		logic count_more;  // another step fits
		logic out_free;    // output register can take an event
		logic emit_last;   // current event ends the run
	} dp_status_t;

	// Slot of event i for a run of the given step count.
	function automatic logic [2:0] slot_of(input logic [2:0] steps, input logic [2:0] i);
		logic [14:0] pat;
		unique case (steps)
			3'd1:    pat = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
			3'd2:    pat = {3'd0, 3'd0, 3'd0, 3'd3, 3'd1};
			3'd3:    pat = {3'd0, 3'd0, 3'd3, 3'd2, 3'd1};
			3'd4:    pat = {3'd0, 3'd4, 3'd3, 3'd1, 3'd0};
			3'd5:    pat = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
			default: pat = '0;
		endcase
		if (i < 3'(NUM_SLOTS))
			return pat[int'(i)*3 +: 3];
		return 3'd0;
	endfunction

endpackage

// ===== hdl/ecd_stream_if.sv =====
// Valid/ready channel carrying one request of a payload type.
// Depends on nothing; the payload types come from ecd_pkg at instantiation.
interface ecd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/event_pixel_change_detector.sv =====
// Top level of the event pixel change detector: controller, datapath, channels.
// Depends on ecd_pkg, ecd_stream_if, ecd_ctrl, ecd_datapath and ecd_ram.
//
//   channel  modport  payload      moves
//   pixel    sink     pixel_req_t  sample or threshold load request
//   events   source   event_req_t  one event request per fired slot
//   cfg      sink     cfg_req_t    register write request, always ready
//
// Sequence: a threshold load, a first-frame sample or a pixel outside the frame
// is taken in ST_IDLE alone; a live sample passes ST_READ and ST_EVAL, and if it
// fires, ST_COUNT (interpolating mode only), ST_UPDATE and ST_EMIT. The sequence
// follows from the registered read of the reference and threshold RAMs, the step
// counter that adds one threshold per cycle, and the one-deep event register.
// Reset clears the controller, the frame-live flag and the mode registers; the
// pixel RAMs are not cleared. A stalled event output holds the run in place.
module event_pixel_change_detector
	import ecd_pkg::*;
#(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input logic        clk,
	input logic        arst_n,
	ecd_stream_if.sink   pixel,
	ecd_stream_if.source events,
	ecd_stream_if.sink   cfg
);
	ctrl_cmd_t  cmd;
	dp_status_t status;
	pixel_req_t pixel_data;
	cfg_req_t   cfg_data;
	event_req_t event_data;

	// Configuration writes go straight into the mode registers, so never stall them.
	assign cfg.ready  = 1'b1;
	assign pixel_data = pixel.data;
	assign cfg_data   = cfg.data;
	assign events.data = event_data;

	ecd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ecd_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (pixel_data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg_data),
		.out_ready (events.ready),
		.out_valid (events.valid),
		.out_data  (event_data),
		.cmd       (cmd),
		.status    (status)
	);
endmodule

// ===== hdl/ecd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ecd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/ecd_ctrl.sv =====
// Sequencing state machine of the change detector.
// Depends on ecd_pkg; drives the datapath through ctrl_cmd_t only.
module ecd_ctrl
	import ecd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.live)
						state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load_diff = 1'b1;
				state_d       = ST_EVAL;
			end
			ST_EVAL: begin
				if (!status.fire) begin
					state_d = ST_IDLE;
				end else begin
					cmd.count_init = 1'b1;
					state_d        = status.interp ? ST_COUNT : ST_UPDATE;
				end
			end
			ST_COUNT: begin
				if (status.count_more)
					cmd.count_step = 1'b1;
				else
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.write_ref  = 1'b1;
				cmd.clear_emit = 1'b1;
				state_d        = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.emit_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== hdl/ecd_datapath.sv =====
// Datapath: pixel stores, magnitude, step counter, reference update, event register.
// Depends on ecd_pkg and ecd_ram; steered by ecd_ctrl through command and status.
module ecd_datapath
	import ecd_pkg::*;
#(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pixel_req_t in_data,
	input  logic       cfg_we,
	input  cfg_req_t   cfg_data,
	input  logic       out_ready,
	output logic       out_valid,
	output event_req_t out_data,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status
);
	localparam int NPIX = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW   = $clog2(NPIX);

	logic          in_frame;
	logic [20:0]   lin_addr;
	logic [AW-1:0] in_addr;

	logic               ref_valid_q, interp_q, full_q;
	logic [6:0]         col_q, row_q;
	logic [LEVEL_W-1:0] value_q, ref_q, thr_q, mag_q;
	logic               rose_q;
	logic [AW-1:0]      addr_q;
	logic [2:0]         steps_q, idx_q, n_events;
	logic [MOVE_W-1:0]  move_q, next_move;

	logic [LEVEL_W-1:0] ref_rd, thr_rd, new_ref;
	logic [MOVE_W:0]    rise_sum;
	logic               rd_rose;

	logic               ref_we, thr_we;
	logic [AW-1:0]      ref_waddr;
	logic [LEVEL_W-1:0] ref_wdata;

	assign in_frame = (11'(in_data.col) < 11'(FRAME_WIDTH)) &&
	                  (11'(in_data.row) < 11'(FRAME_HEIGHT));
	assign lin_addr = 21'(in_data.row) * 21'(FRAME_WIDTH) + 21'(in_data.col);
	assign in_addr  = lin_addr[AW-1:0];

	// Stores: threshold loads and first-frame samples write at accept,
	// the reference update writes back at its own step.
	assign thr_we    = cmd.capture && (in_data.command == CMD_THRESHOLD) && in_frame;
	assign ref_we    = (cmd.capture && (in_data.command == CMD_SAMPLE) && in_frame &&
	                   !ref_valid_q) || cmd.write_ref;
	assign ref_waddr = cmd.write_ref ? addr_q : in_addr;
	assign ref_wdata = cmd.write_ref ? new_ref : in_data.value;

	ecd_ram #(.WIDTH(LEVEL_W), .DEPTH(NPIX)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.raddr (in_addr),
		.rdata (ref_rd)
	);

	ecd_ram #(.WIDTH(LEVEL_W), .DEPTH(NPIX)) u_thr_ram (
		.clk   (clk),
		.we    (thr_we),
		.waddr (in_addr),
		.wdata (in_data.value),
		.raddr (in_addr),
		.rdata (thr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid_q <= 1'b0;
			interp_q    <= 1'b1;
			full_q      <= 1'b0;
		end else begin
			if (cmd.capture && (in_data.command == CMD_SAMPLE) && in_data.frame_end)
				ref_valid_q <= 1'b1;
			if (cfg_we) begin
				if (cfg_data.index == CFG_INTERPOLATE)
					interp_q <= cfg_data.wdata[0];
				else if (cfg_data.index == CFG_FULL_UPDATE)
					full_q <= cfg_data.wdata[0];
			end
		end
	end

	assign rd_rose   = value_q > ref_rd;
	assign next_move = move_q + MOVE_W'(thr_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q   <= in_data.col;
			row_q   <= in_data.row;
			value_q <= in_data.value;
			addr_q  <= in_addr;
		end
		if (cmd.load_diff) begin
			ref_q  <= ref_rd;
			thr_q  <= thr_rd;
			rose_q <= rd_rose;
			mag_q  <= rd_rose ? value_q - ref_rd : ref_rd - value_q;
		end
		if (cmd.count_init) begin
			steps_q <= 3'd1;
			move_q  <= MOVE_W'(thr_q);
		end else if (cmd.count_step) begin
			steps_q <= steps_q + 3'd1;
			move_q  <= next_move;
		end
		if (cmd.clear_emit)
			idx_q <= 3'd0;
		else if (cmd.emit)
			idx_q <= idx_q + 3'd1;
	end

	// New reference: the sample itself, or moved by steps * threshold, clamped.
	assign rise_sum = (MOVE_W+1)'(ref_q) + (MOVE_W+1)'(move_q);
	always_comb begin
		if (!interp_q || full_q)
			new_ref = value_q;
		else if (rose_q)
			new_ref = (rise_sum > (MOVE_W+1)'(16'hFFFF)) ? 16'hFFFF : rise_sum[LEVEL_W-1:0];
		else
			new_ref = (move_q > MOVE_W'(ref_q)) ? '0 : ref_q - move_q[LEVEL_W-1:0];
	end

	assign n_events = interp_q ? steps_q : 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data.event_col   <= col_q;
			out_data.event_row   <= row_q;
			out_data.polarity    <= rose_q;
			out_data.slot        <= interp_q ? slot_of(steps_q, idx_q) : 3'd0;
			out_data.last_of_run <= status.emit_last;
		end
	end

	assign status.live       = (in_data.command == CMD_SAMPLE) && in_frame && ref_valid_q;
	assign status.fire       = mag_q > thr_q;
	assign status.interp     = interp_q;
	assign status.count_more = (steps_q < 3'(NUM_SLOTS)) &&
	                           (MOVE_W'(mag_q) > next_move);
	assign status.out_free   = !out_valid || out_ready;
	assign status.emit_last  = (idx_q + 3'd1) == n_events;
endmodule
